/* rtl/egcd_pkg.sv */
// egcd_pkg: shared types and constants for the extended Euclid GCD block.
// No dependencies.
`timescale 1ns / 1ps

package egcd_pkg;

   localparam int COEFF_WIDTH = 32;

   typedef struct packed {
      logic load;
      logic div_start;
      logic div_step;
      logic update;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic rem_zero;
   } status_type;

endpackage

/* rtl/egcd_datapath.sv */
// egcd_datapath: remainder and Bezout coefficient registers, bit-serial divider
// with shift-add quotient products. Depends on egcd_pkg.
`timescale 1ns / 1ps

module egcd_datapath #(
   parameter int OPERAND_WIDTH = 31
) (
   input  logic                                  clock,
   input  egcd_pkg::cmd_type                     cmd,
   output egcd_pkg::status_type                  status,
   input  logic [OPERAND_WIDTH-1:0]              first_operand,
   input  logic [OPERAND_WIDTH-1:0]              second_operand,
   output logic [OPERAND_WIDTH-1:0]              divisor,
   output logic signed [egcd_pkg::COEFF_WIDTH-1:0] coeff_a,
   output logic signed [egcd_pkg::COEFF_WIDTH-1:0] coeff_b
);

   localparam int CW = egcd_pkg::COEFF_WIDTH;

   logic [OPERAND_WIDTH-1:0] r0_ff, r0_in, r1_ff, r1_in;
   logic [OPERAND_WIDTH-1:0] rem_ff, rem_in, dvd_ff, dvd_in;
   logic [CW-1:0]            u0_ff, u0_in, u1_ff, u1_in, v0_ff, v0_in, v1_ff, v1_in;
   logic [CW-1:0]            acc_u_ff, acc_u_in, acc_v_ff, acc_v_in;
   logic [OPERAND_WIDTH-1:0] out_d_ff, out_d_in;
   logic [CW-1:0]            out_u_ff, out_u_in, out_v_ff, out_v_in;

   logic [OPERAND_WIDTH:0]   shifted;
   logic [OPERAND_WIDTH-1:0] diff;
   logic                     qbit;

   assign shifted = {rem_ff, dvd_ff[OPERAND_WIDTH-1]};
   assign diff    = shifted[OPERAND_WIDTH-1:0] - r1_ff;
   assign qbit    = (shifted >= {1'b0, r1_ff});

   always_comb begin
      r0_in    = r0_ff;
      r1_in    = r1_ff;
      u0_in    = u0_ff;
      u1_in    = u1_ff;
      v0_in    = v0_ff;
      v1_in    = v1_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      acc_u_in = acc_u_ff;
      acc_v_in = acc_v_ff;
      out_d_in = out_d_ff;
      out_u_in = out_u_ff;
      out_v_in = out_v_ff;
      if (cmd.load) begin
         r0_in = first_operand;
         r1_in = second_operand;
         u0_in = CW'(1);
         v0_in = '0;
         u1_in = '0;
         v1_in = CW'(1);
      end
      if (cmd.div_start) begin
         rem_in   = '0;
         dvd_in   = r0_ff;
         acc_u_in = '0;
         acc_v_in = '0;
      end
      if (cmd.div_step) begin
         rem_in   = qbit ? diff : shifted[OPERAND_WIDTH-1:0];
         dvd_in   = {dvd_ff[OPERAND_WIDTH-2:0], 1'b0};
         acc_u_in = {acc_u_ff[CW-2:0], 1'b0} + (qbit ? u1_ff : '0);
         acc_v_in = {acc_v_ff[CW-2:0], 1'b0} + (qbit ? v1_ff : '0);
      end
      if (cmd.update) begin
         r0_in = r1_ff;
         r1_in = rem_ff;
         u0_in = u1_ff;
         v0_in = v1_ff;
         u1_in = u0_ff - acc_u_ff;
         v1_in = v0_ff - acc_v_ff;
      end
      if (cmd.finish) begin
         out_d_in = r0_ff;
         out_u_in = u0_ff;
         out_v_in = v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      r0_ff    <= r0_in;
      r1_ff    <= r1_in;
      u0_ff    <= u0_in;
      u1_ff    <= u1_in;
      v0_ff    <= v0_in;
      v1_ff    <= v1_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      acc_u_ff <= acc_u_in;
      acc_v_ff <= acc_v_in;
      out_d_ff <= out_d_in;
      out_u_ff <= out_u_in;
      out_v_ff <= out_v_in;
   end

   assign status.rem_zero = (r1_ff == '0);
   assign divisor = out_d_ff;
   assign coeff_a = out_u_ff;
   assign coeff_b = out_v_ff;

endmodule

/* rtl/egcd_ctrl.sv */
// egcd_ctrl: sequencer for the Euclid passes and the bit-serial division.
// Depends on egcd_pkg.
`timescale 1ns / 1ps

module egcd_ctrl #(
   parameter int OPERAND_WIDTH = 31
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output egcd_pkg::cmd_type    cmd,
   input  egcd_pkg::status_type status
);

   localparam int CNT_W = $clog2(OPERAND_WIDTH);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(OPERAND_WIDTH - 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CHECK  = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;
   localparam logic [1:0] ST_UPDATE = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      valid_in = 1'b0;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.rem_zero) begin
               cmd.finish = 1'b1;
               valid_in   = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               cnt_in        = '0;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_CHECK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

/* rtl/extended_euclid_gcd_top.sv */
// extended_euclid_gcd_top: extended Euclid GCD with Bezout coefficients.
// A request runs k Euclid passes between start and rsp_valid (k up to about 46
// at 31 bits); each pass is one bit-serial division, one quotient bit per cycle.
// One beat in flight; start is taken when busy is low, including the cycle
// rsp_valid is high. Results cannot be stalled.
// Synchronous active-high reset returns the sequencer to idle with no result pending.
`timescale 1ns / 1ps

module extended_euclid_gcd_top #(
   parameter int OPERAND_WIDTH = 31
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [OPERAND_WIDTH-1:0]              req_first_operand,
   input  logic [OPERAND_WIDTH-1:0]              req_second_operand,
   output logic                                  rsp_valid,
   output logic [OPERAND_WIDTH-1:0]              rsp_divisor,
   output logic signed [egcd_pkg::COEFF_WIDTH-1:0] rsp_coeff_a,
   output logic signed [egcd_pkg::COEFF_WIDTH-1:0] rsp_coeff_b
);

   egcd_pkg::cmd_type    cmd;
   egcd_pkg::status_type status;

   egcd_ctrl #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .cmd      (cmd),
      .status   (status)
   );

   egcd_datapath #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .status        (status),
      .first_operand (req_first_operand),
      .second_operand(req_second_operand),
      .divisor       (rsp_divisor),
      .coeff_a       (rsp_coeff_a),
      .coeff_b       (rsp_coeff_b)
   );

endmodule
